### hw/rtl/rrmps_pkg.sv
`default_nettype none

package rrmps_pkg;

    localparam int WORD_W = 32;
    localparam int BIT_W  = 5;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_ADDR_W-1:0] REG_NUM_PACKETS       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_SLEEP         = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SLEEP_STEP        = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_RECEIVE_THRESHOLD = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_LENGTH     = 3'd4;

    localparam logic [1:0] OP_PICK = 2'd0;
    localparam logic [1:0] OP_SENT = 2'd1;
    localparam logic [1:0] OP_RESP = 2'd2;

    localparam logic [10:0] NUM_PACKETS_RST       = 11'd1024;
    localparam logic [19:0] MIN_SLEEP_RST         = 20'd8000;
    localparam logic [15:0] SLEEP_STEP_RST        = 16'd200;
    localparam logic [7:0]  RECEIVE_THRESHOLD_RST = 8'd9;
    localparam logic [7:0]  WINDOW_LENGTH_RST     = 8'd11;

    localparam logic [19:0] DELAY_MAX = 20'hFFFFF;
    localparam logic [7:0]  COUNT_MAX = 8'hFF;

    localparam int DIV_NUM_W = 21;
    localparam int DIV_DEN_W = 17;
    localparam int DIV_CNT_W = 5;

    typedef logic [DIV_NUM_W-1:0] div_num_t;
    typedef logic [DIV_DEN_W-1:0] div_den_t;

    typedef struct packed {
        logic     start;
        div_num_t dividend;
        div_den_t divisor;
    } div_req_t;

    typedef struct packed {
        logic     done;
        div_num_t quotient;
        div_den_t remainder;
    } div_rsp_t;

    function automatic logic [WORD_W-1:0] low_mask(input logic [BIT_W-1:0] b);
        return ~({WORD_W{1'b1}} << b);
    endfunction

    function automatic logic [BIT_W-1:0] first_one(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/round_robin_missing_packet_scheduler_top.sv
// Round-robin scheduler for re-requesting missing chunks. Each input item is a pick
// (op 0), a request-sent notice (op 1) or a response (op 2), and gives exactly one
// result item with the picked chunk, its byte offset, the current delay and the
// done flags. The received bitmap sits in a single-port-read memory of 32-bit words;
// every item ends with a scan over the words covering num_packets. A sent item goes
// through the bit-serial divider that wraps the pointer by the chunk count; a
// response with data finds its chunk by reciprocal multiplication, then does a
// read-modify-write on the bitmap when that chunk is in range. A result that is not
// taken holds the next item in its last cycle. After reset the bitmap is cleared one
// word per cycle while no item is taken; the user is to make configuration writes
// only while the block is idle or during that pass, and the block itself does not
// enforce it.
`default_nettype none

module round_robin_missing_packet_scheduler_top #(
    parameter int MAX_PACKETS  = 1024,
    parameter int PACKET_BYTES = 1448
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [23:0]                       s_axis_tdata,  // resp_offset, resp_has_data
    input  wire logic [1:0]                        s_axis_tuser,  // op

    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // chunk_index, request_offset, delay_us, newly_received, all_done
    output logic [55:0]                            m_axis_tdata,

    input  wire logic                              cfg_we,
    input  wire logic [rrmps_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [rrmps_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int IW    = $clog2(MAX_PACKETS);
    localparam int CW    = $clog2(MAX_PACKETS + 1);
    localparam int WORDS = (MAX_PACKETS + rrmps_pkg::WORD_W - 1) / rrmps_pkg::WORD_W;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PW    = AW + rrmps_pkg::BIT_W;
    localparam int BW    = rrmps_pkg::BIT_W;
    localparam int WW    = rrmps_pkg::WORD_W;

    localparam int RCP_SH = rrmps_pkg::DIV_NUM_W + $clog2(PACKET_BYTES);
    localparam int RCP_W  = rrmps_pkg::DIV_NUM_W + 1;
    localparam int PRD_W  = rrmps_pkg::DIV_NUM_W + RCP_W;
    localparam logic [RCP_W-1:0] RCP =
        RCP_W'(((64'd1 << RCP_SH) + 64'(PACKET_BYTES) - 64'd1) / 64'(PACKET_BYTES));

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_RD    = 3'd3;
    localparam logic [2:0] ST_MOD   = 3'd4;
    localparam logic [2:0] ST_SCAN  = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;
    localparam logic [2:0] ST_LOAD  = 3'd7;

    logic [2:0]      state_reg;

    logic [10:0]     num_packets_reg;
    logic [19:0]     min_sleep_reg;
    logic [15:0]     sleep_step_reg;
    logic [7:0]      threshold_reg;
    logic [7:0]      window_reg;

    logic [IW-1:0]   ptr_reg;
    logic [IW-1:0]   picked_reg;
    logic [7:0]      slot_reg;
    logic [7:0]      resp_cnt_reg;
    logic [19:0]     delay_reg;
    logic [10:0]     total_reg;

    logic [1:0]      op_reg;
    logic            newly_reg;
    logic            done_reg;
    logic [PW-1:0]   mark_reg;
    rrmps_pkg::div_num_t offset_reg;

    logic [AW-1:0]   clr_cnt_reg;
    logic [AW:0]     iss_cnt_reg;
    logic            pvalid_reg;
    logic [AW-1:0]   pword_reg;
    logic            any_found_reg;
    logic [PW-1:0]   any_idx_reg;
    logic            aft_found_reg;
    logic [PW-1:0]   aft_idx_reg;

    logic [WW-1:0]   mem [WORDS];
    logic [WW-1:0]   mem_rdata_reg;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [WW-1:0]   mem_wdata;
    logic [AW-1:0]   mem_raddr;

    logic            m_valid_reg;
    logic [55:0]     m_data_reg;

    rrmps_pkg::div_req_t div_req;
    rrmps_pkg::div_rsp_t div_rsp;

    logic            accept;
    logic [1:0]      in_op;
    logic [20:0]     in_offset;
    logic            in_has_data;
    logic            need_mark;

    logic [PRD_W-1:0]    quo_prod;
    rrmps_pkg::div_num_t quo;

    logic [CW-1:0]   lim;
    logic [PW:0]     lim_p;
    logic [AW:0]     nword;
    logic [BW-1:0]   nbit;
    logic [AW:0]     scan_end;
    logic            issue;
    logic [PW-1:0]   ptr_p;
    logic [AW-1:0]   ptr_word;
    logic [BW-1:0]   ptr_bit;
    logic [WW-1:0]   lim_mask;
    logic [WW-1:0]   ptr_mask;
    logic [WW-1:0]   pend;
    logic [WW-1:0]   aft;
    logic            mark_bit;
    logic            out_free;

    logic [7:0]      win;
    logic [7:0]      slot_inc;
    logic [20:0]     delay_sum;
    logic [19:0]     delay_up;
    logic [19:0]     delay_dn;
    logic [19:0]     delay_dn_floor;
    logic [19:0]     delay_adj;
    logic [7:0]      resp_cnt_next;

    assign accept      = s_axis_tvalid && s_axis_tready;
    assign in_op       = s_axis_tuser;
    assign in_offset   = s_axis_tdata[20:0];
    assign in_has_data = s_axis_tdata[21];
    assign need_mark   = (in_op == rrmps_pkg::OP_RESP) && in_has_data;

    assign quo_prod = PRD_W'(offset_reg) * PRD_W'(RCP);
    assign quo      = rrmps_pkg::div_num_t'(quo_prod >> RCP_SH);

    always_comb
    begin
        if (num_packets_reg == 11'd0)
        begin
            lim = CW'(1);
        end
        else if (32'(num_packets_reg) > 32'(MAX_PACKETS))
        begin
            lim = CW'(MAX_PACKETS);
        end
        else
        begin
            lim = CW'(num_packets_reg);
        end
    end

    assign lim_p    = (PW + 1)'(lim);
    assign nword    = lim_p[PW:BW];
    assign nbit     = lim_p[BW-1:0];
    assign scan_end = nword + (AW + 1)'(nbit != '0);
    assign issue    = (state_reg == ST_SCAN) && (iss_cnt_reg < scan_end);

    assign ptr_p    = PW'(ptr_reg);
    assign ptr_word = ptr_p[PW-1:BW];
    assign ptr_bit  = ptr_p[BW-1:0];

    always_comb
    begin
        if ({1'b0, pword_reg} < nword)
        begin
            lim_mask = '1;
        end
        else if ({1'b0, pword_reg} == nword)
        begin
            lim_mask = rrmps_pkg::low_mask(nbit);
        end
        else
        begin
            lim_mask = '0;
        end

        if (pword_reg > ptr_word)
        begin
            ptr_mask = '1;
        end
        else if (pword_reg == ptr_word)
        begin
            ptr_mask = ~rrmps_pkg::low_mask(ptr_bit);
        end
        else
        begin
            ptr_mask = '0;
        end
    end

    assign pend     = ~mem_rdata_reg & lim_mask;
    assign aft      = pend & ptr_mask;
    assign mark_bit = mem_rdata_reg[mark_reg[BW-1:0]];
    assign out_free = !m_valid_reg || m_axis_tready;

    // delay adjustment at window end
    assign win       = (window_reg == 8'd0) ? 8'd1 : window_reg;
    assign slot_inc  = slot_reg + 8'd1;
    assign delay_sum = {1'b0, delay_reg} + {5'd0, sleep_step_reg};
    assign delay_up  = (delay_sum > {1'b0, rrmps_pkg::DELAY_MAX}) ? rrmps_pkg::DELAY_MAX
                                                                  : delay_sum[19:0];
    assign delay_dn  = (delay_reg > {4'd0, sleep_step_reg})
                     ? delay_reg - {4'd0, sleep_step_reg} : 20'd0;
    assign delay_dn_floor = (delay_dn < min_sleep_reg) ? min_sleep_reg : delay_dn;
    assign delay_adj = (resp_cnt_reg < threshold_reg) ? delay_up : delay_dn_floor;
    assign resp_cnt_next = (resp_cnt_reg == rrmps_pkg::COUNT_MAX) ? resp_cnt_reg
                                                                  : resp_cnt_reg + 8'd1;

    always_comb
    begin
        div_req.start    = accept && (in_op == rrmps_pkg::OP_SENT);
        div_req.dividend = rrmps_pkg::div_num_t'(picked_reg) + 1'b1;
        div_req.divisor  = rrmps_pkg::div_den_t'(lim);
    end

    rrmps_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = mark_reg[PW-1:BW];
        mem_wdata = mem_rdata_reg | (WW'(1) << mark_reg[BW-1:0]);
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else if (state_reg == ST_MOD)
        begin
            mem_we = !mark_bit;
        end
        mem_raddr = (state_reg == ST_RD) ? mark_reg[PW-1:BW] : iss_cnt_reg[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            num_packets_reg <= rrmps_pkg::NUM_PACKETS_RST;
            min_sleep_reg   <= rrmps_pkg::MIN_SLEEP_RST;
            sleep_step_reg  <= rrmps_pkg::SLEEP_STEP_RST;
            threshold_reg   <= rrmps_pkg::RECEIVE_THRESHOLD_RST;
            window_reg      <= rrmps_pkg::WINDOW_LENGTH_RST;
            ptr_reg         <= '0;
            picked_reg      <= '0;
            slot_reg        <= '0;
            resp_cnt_reg    <= '0;
            delay_reg       <= rrmps_pkg::MIN_SLEEP_RST;
            total_reg       <= '0;
            op_reg          <= rrmps_pkg::OP_PICK;
            newly_reg       <= 1'b0;
            done_reg        <= 1'b0;
            mark_reg        <= '0;
            offset_reg      <= '0;
            clr_cnt_reg     <= '0;
            iss_cnt_reg     <= '0;
            pvalid_reg      <= 1'b0;
            pword_reg       <= '0;
            any_found_reg   <= 1'b0;
            any_idx_reg     <= '0;
            aft_found_reg   <= 1'b0;
            aft_idx_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    rrmps_pkg::REG_NUM_PACKETS:       num_packets_reg <= cfg_wdata[10:0];
                    rrmps_pkg::REG_MIN_SLEEP:
                    begin
                        min_sleep_reg <= cfg_wdata;
                        delay_reg     <= cfg_wdata;
                    end
                    rrmps_pkg::REG_SLEEP_STEP:        sleep_step_reg  <= cfg_wdata[15:0];
                    rrmps_pkg::REG_RECEIVE_THRESHOLD: threshold_reg   <= cfg_wdata[7:0];
                    rrmps_pkg::REG_WINDOW_LENGTH:     window_reg      <= cfg_wdata[7:0];
                    default: ;
                endcase
            end

            if ((state_reg == ST_LOAD) && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            pvalid_reg <= issue;
            pword_reg  <= iss_cnt_reg[AW-1:0];

            case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == AW'(WORDS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    iss_cnt_reg   <= '0;
                    any_found_reg <= 1'b0;
                    aft_found_reg <= 1'b0;
                    if (accept)
                    begin
                        op_reg     <= in_op;
                        offset_reg <= in_offset;
                        newly_reg  <= 1'b0;
                        state_reg  <= (div_req.start || need_mark) ? ST_DIV : ST_SCAN;
                    end
                end
                ST_DIV:
                begin
                    if (op_reg == rrmps_pkg::OP_SENT)
                    begin
                        if (div_rsp.done)
                        begin
                            ptr_reg   <= IW'(div_rsp.remainder);
                            state_reg <= ST_SCAN;
                        end
                    end
                    else if (quo < rrmps_pkg::div_num_t'(lim))
                    begin
                        mark_reg  <= PW'(quo);
                        state_reg <= ST_RD;
                    end
                    else
                    begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_RD:
                begin
                    state_reg <= ST_MOD;
                end
                ST_MOD:
                begin
                    if (!mark_bit)
                    begin
                        newly_reg <= 1'b1;
                        total_reg <= total_reg + 11'd1;
                    end
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (issue)
                    begin
                        iss_cnt_reg <= iss_cnt_reg + 1'b1;
                    end
                    if (pvalid_reg)
                    begin
                        if ((pend != '0) && !any_found_reg)
                        begin
                            any_found_reg <= 1'b1;
                            any_idx_reg   <= {pword_reg, rrmps_pkg::first_one(pend)};
                        end
                        if ((aft != '0) && !aft_found_reg)
                        begin
                            aft_found_reg <= 1'b1;
                            aft_idx_reg   <= {pword_reg, rrmps_pkg::first_one(aft)};
                        end
                    end
                    if (!issue && !pvalid_reg)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    done_reg <= !any_found_reg;
                    case (op_reg)
                        rrmps_pkg::OP_PICK:
                        begin
                            if (any_found_reg)
                            begin
                                if (slot_inc >= win)
                                begin
                                    slot_reg     <= '0;
                                    delay_reg    <= delay_adj;
                                    resp_cnt_reg <= '0;
                                end
                                else
                                begin
                                    slot_reg <= slot_inc;
                                end
                                picked_reg <= aft_found_reg ? IW'(aft_idx_reg)
                                                            : IW'(any_idx_reg);
                            end
                        end
                        rrmps_pkg::OP_RESP:
                        begin
                            resp_cnt_reg <= resp_cnt_next;
                        end
                        default: ;
                    endcase
                    state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_LOAD) && out_free)
        begin
            m_data_reg <= {3'd0,
                           done_reg,
                           newly_reg,
                           delay_reg,
                           21'(32'(picked_reg) * 32'(PACKET_BYTES)),
                           10'(picked_reg)};
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

`default_nettype wire

### hw/rtl/rrmps_div.sv
`default_nettype none

module rrmps_div (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire rrmps_pkg::div_req_t req,
    output rrmps_pkg::div_rsp_t      rsp
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [rrmps_pkg::DIV_CNT_W-1:0]     cnt_reg;
    rrmps_pkg::div_num_t                 num_reg;
    rrmps_pkg::div_den_t                 rem_reg;
    rrmps_pkg::div_den_t                 den_reg;

    logic [rrmps_pkg::DIV_DEN_W:0]       shifted;
    logic                                ge;
    rrmps_pkg::div_den_t                 rem_next;

    assign shifted  = {rem_reg, num_reg[rrmps_pkg::DIV_NUM_W-1]};
    assign ge       = shifted >= {1'b0, den_reg};
    assign rem_next = ge ? rrmps_pkg::div_den_t'(shifted - {1'b0, den_reg})
                         : shifted[rrmps_pkg::DIV_DEN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == rrmps_pkg::DIV_CNT_W'(rrmps_pkg::DIV_NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.dividend;
            den_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[rrmps_pkg::DIV_NUM_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = num_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

### hw/rtl/rrmps_chk.sv
`default_nettype none

module rrmps_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [55:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("new item taken while one is still at work");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result item shown without an item at work");

endmodule

bind round_robin_missing_packet_scheduler_top rrmps_chk u_rrmps_chk (.*);

`default_nettype wire
